// ===== design/pid_deadband_antiwindup_top_defines.svh =====
// ----------------------------------------------------------------------------
// PID deadband anti-windup: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef PID_DEADBAND_ANTIWINDUP_TOP_DEFINES_SVH
`define PID_DEADBAND_ANTIWINDUP_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PDA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pda check failed");

// next-cycle implication, sampled on clk, off during reset
`define PDA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pda check failed");

`endif

// ===== design/pda_pkg.sv =====
// ----------------------------------------------------------------------------
// PID deadband anti-windup package
// Shared types and constants for controller and datapath.
// ----------------------------------------------------------------------------
package pda_pkg;

    localparam int DIV_W = 49;

    localparam logic [2:0] REG_KP   = 3'd0;
    localparam logic [2:0] REG_KI   = 3'd1;
    localparam logic [2:0] REG_KD   = 3'd2;
    localparam logic [2:0] REG_DB   = 3'd3;
    localparam logic [2:0] REG_MAXC = 3'd4;

    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    localparam logic signed [32:0] EPS_Q16   = 33'sd7;
    localparam logic [47:0]        INTEG_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [61:0]        TERM_CAP  = 62'h2000_0000_0000_0000;

    typedef struct packed {
        logic       load_sample;
        logic       start_div;
        logic       acc_calc;
        logic       upd_state;
        logic       mload;
        logic       mstep;
        logic       msum;
        logic       load_out;
        logic [1:0] term;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

// ===== design/pda_div.sv =====
// ----------------------------------------------------------------------------
// PDA restoring divider
// Unsigned 49-bit by 32-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pda_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pda_pkg::DIV_W-1:0] num,
    input  logic [31:0]               den,
    output logic                      busy,
    output logic [pda_pkg::DIV_W-1:0] quo
);

    logic [pda_pkg::DIV_W-1:0] q_reg;
    logic [31:0]               rem_reg;
    logic [31:0]               den_reg;
    logic [5:0]                cnt_reg;
    logic                      busy_reg;
    logic [32:0]               rem_sh;
    logic [33:0]               trial;

    assign rem_sh = {rem_reg, q_reg[pda_pkg::DIV_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(pda_pkg::DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            // keep the trial remainder when the divisor fits
            if (!trial[33])
            begin
                rem_reg <= trial[31:0];
                q_reg   <= {q_reg[pda_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                q_reg   <= {q_reg[pda_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

// ===== design/pda_dp.sv =====
// ----------------------------------------------------------------------------
// PDA datapath
// Config registers, controller state, dividers, chunked multiplier, output.
// ----------------------------------------------------------------------------
module pda_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pda_pkg::cmd_t        cmd,
    output pda_pkg::sts_t        sts,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic signed [31:0]   err_sample,
    input  logic [15:0]          time_step,
    input  logic                 result_stall,
    output logic                 result_valid,
    output logic signed [31:0]   correction,
    output logic                 out_clamped,
    output logic                 integ_clamped,
    output logic                 step_zero
);

    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [30:0]        db_reg, maxc_reg;

    logic signed [31:0] e_reg;
    logic [15:0]        dt_reg;
    logic signed [32:0] inc_reg;
    logic               diff_neg_reg;
    logic               den_zero_reg;
    logic signed [48:0] acc_raw_reg;
    logic signed [47:0] integ_acc_reg;
    logic signed [31:0] last_err_reg;
    logic signed [49:0] d_reg;
    logic               iclamp_reg;

    logic [31:0]        gmag_reg;
    logic [63:0]        omag_reg;
    logic               neg_reg;
    logic [79:0]        pacc_reg;
    logic signed [63:0] sum_reg;

    logic signed [31:0] correction_reg;
    logic               oclamp_reg, iclamp_out_reg, zero_out_reg, result_valid_reg;

    // deadband
    logic signed [32:0] e_ext, db_ext;
    logic               in_band;

    assign e_ext   = {err_sample[31], err_sample};
    assign db_ext  = {2'b00, db_reg};
    assign in_band = (e_ext > -db_ext) && (e_ext < db_ext);

    // integral increment and divider operands
    logic signed [48:0] prod_ed;
    logic signed [32:0] diff, den_g;
    logic [32:0]        diff_mag, den_mag;
    logic [pda_pkg::DIV_W-1:0] q_lim, q_d;
    logic               busy_lim, busy_d;

    assign prod_ed  = e_reg * $signed({1'b0, dt_reg});
    assign diff     = {e_reg[31], e_reg} - {last_err_reg[31], last_err_reg};
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign den_g    = {ki_reg[31], ki_reg} + pda_pkg::EPS_Q16;
    assign den_mag  = den_g[32] ? 33'(-den_g) : 33'(den_g);

    pda_div u_div_lim
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_div),
        .num   ({2'b00, maxc_reg, 16'h0000}),
        .den   (den_mag[31:0]),
        .busy  (busy_lim),
        .quo   (q_lim)
    );

    pda_div u_div_d
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_div),
        .num   ({diff_mag, 16'h0000}),
        .den   ({16'h0000, dt_reg}),
        .busy  (busy_d),
        .quo   (q_d)
    );

    // integral clamp
    logic [47:0]        lim;
    logic signed [48:0] lim_ext;

    assign lim     = den_zero_reg ? pda_pkg::INTEG_MAX : q_lim[47:0];
    assign lim_ext = {1'b0, lim};

    // term operand select
    logic signed [31:0] g_sel;
    logic signed [49:0] o_sel;
    logic [31:0]        g_mag;
    logic [49:0]        o_mag;

    always_comb
    begin
        case (cmd.term)
            pda_pkg::TERM_P:
            begin
                g_sel = kp_reg;
                o_sel = 50'(e_reg);
            end
            pda_pkg::TERM_I:
            begin
                g_sel = ki_reg;
                o_sel = 50'(integ_acc_reg);
            end
            default:
            begin
                g_sel = kd_reg;
                o_sel = d_reg;
            end
        endcase
    end

    assign g_mag = g_sel[31] ? 32'(-g_sel) : 32'(g_sel);
    assign o_mag = o_sel[49] ? 50'(-o_sel) : 50'(o_sel);

    logic [47:0]        pp;
    logic [61:0]        m_sat;
    logic signed [63:0] term_val;

    assign pp       = gmag_reg * omag_reg[63:48];
    assign m_sat    = (pacc_reg > {18'd0, pda_pkg::TERM_CAP}) ? pda_pkg::TERM_CAP
                                                             : pacc_reg[61:0];
    assign term_val = neg_reg ? -$signed({2'b00, m_sat}) : $signed({2'b00, m_sat});

    // output clamp
    logic signed [47:0] y, mc_ext;

    assign y      = sum_reg[63:16];
    assign mc_ext = {17'd0, maxc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg           <= '0;
            ki_reg           <= '0;
            kd_reg           <= '0;
            db_reg           <= '0;
            maxc_reg         <= '0;
            integ_acc_reg    <= '0;
            last_err_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    pda_pkg::REG_KP:   kp_reg   <= cfg_data;
                    pda_pkg::REG_KI:   ki_reg   <= cfg_data;
                    pda_pkg::REG_KD:   kd_reg   <= cfg_data;
                    pda_pkg::REG_DB:   db_reg   <= cfg_data[30:0];
                    pda_pkg::REG_MAXC: maxc_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (cmd.upd_state)
            begin
                last_err_reg <= e_reg;
                if (acc_raw_reg > lim_ext)
                begin
                    integ_acc_reg <= lim;
                end
                else if (acc_raw_reg < -lim_ext)
                begin
                    integ_acc_reg <= 48'(-lim_ext);
                end
                else
                begin
                    integ_acc_reg <= acc_raw_reg[47:0];
                end
            end
            if (cmd.load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            e_reg   <= in_band ? 32'sd0 : err_sample;
            dt_reg  <= time_step;
            sum_reg <= '0;
        end
        if (cmd.start_div)
        begin
            inc_reg      <= prod_ed[48:16];
            diff_neg_reg <= diff[32];
            den_zero_reg <= (den_g == 33'sd0);
        end
        if (cmd.acc_calc)
        begin
            acc_raw_reg <= {integ_acc_reg[47], integ_acc_reg} + 49'(inc_reg);
        end
        if (cmd.upd_state)
        begin
            iclamp_reg <= (acc_raw_reg > lim_ext) || (acc_raw_reg < -lim_ext);
            if (dt_reg == 16'd0)
            begin
                d_reg <= '0;
            end
            else
            begin
                d_reg <= diff_neg_reg ? -$signed({1'b0, q_d}) : $signed({1'b0, q_d});
            end
        end
        if (cmd.mload)
        begin
            gmag_reg <= g_mag;
            omag_reg <= {14'd0, o_mag};
            neg_reg  <= g_sel[31] ^ o_sel[49];
            pacc_reg <= '0;
        end
        if (cmd.mstep)
        begin
            // most significant chunk first
            pacc_reg <= {pacc_reg[63:0], 16'h0000} + {32'd0, pp};
            omag_reg <= {omag_reg[47:0], 16'h0000};
        end
        if (cmd.msum)
        begin
            sum_reg <= sum_reg + term_val;
        end
        if (cmd.load_out)
        begin
            if (y > mc_ext)
            begin
                correction_reg <= $signed({1'b0, maxc_reg});
                oclamp_reg     <= 1'b1;
            end
            else if (y < -mc_ext)
            begin
                correction_reg <= -$signed({1'b0, maxc_reg});
                oclamp_reg     <= 1'b1;
            end
            else
            begin
                correction_reg <= y[31:0];
                oclamp_reg     <= 1'b0;
            end
            iclamp_out_reg <= iclamp_reg;
            zero_out_reg   <= (dt_reg == 16'd0);
        end
    end

    assign sts.div_busy = busy_lim || busy_d;
    assign sts.out_free = !result_valid_reg || !result_stall;

    assign result_valid  = result_valid_reg;
    assign correction    = correction_reg;
    assign out_clamped   = oclamp_reg;
    assign integ_clamped = iclamp_out_reg;
    assign step_zero     = zero_out_reg;

endmodule

// ===== design/pda_ctrl.sv =====
// ----------------------------------------------------------------------------
// PDA controller
// Sequences one sample through division, clamp, three products and output.
// ----------------------------------------------------------------------------
module pda_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sample_valid,
    output logic          sample_stall,
    output pda_pkg::cmd_t cmd,
    input  pda_pkg::sts_t sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INC   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_CLAMP = 3'd3;
    localparam logic [2:0] ST_MLOAD = 3'd4;
    localparam logic [2:0] ST_MRUN  = 3'd5;
    localparam logic [2:0] ST_MSUM  = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] term_reg, term_next;
    logic [1:0] chunk_reg, chunk_next;

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        chunk_next = chunk_reg;
        cmd        = '0;
        cmd.term   = term_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_INC;
                end
            end
            ST_INC:
            begin
                cmd.start_div = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.acc_calc = 1'b1;
                if (!sts.div_busy)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                cmd.upd_state = 1'b1;
                term_next     = pda_pkg::TERM_P;
                state_next    = ST_MLOAD;
            end
            ST_MLOAD:
            begin
                cmd.mload  = 1'b1;
                chunk_next = '0;
                state_next = ST_MRUN;
            end
            ST_MRUN:
            begin
                cmd.mstep  = 1'b1;
                chunk_next = chunk_reg + 2'd1;
                if (chunk_reg == 2'd3)
                begin
                    state_next = ST_MSUM;
                end
            end
            ST_MSUM:
            begin
                cmd.msum = 1'b1;
                if (term_reg == pda_pkg::TERM_D)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    term_next  = term_reg + 2'd1;
                    state_next = ST_MLOAD;
                end
            end
            ST_FIN:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= '0;
            chunk_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            chunk_reg <= chunk_next;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);

endmodule

// ===== design/pid_deadband_antiwindup_top.sv =====
// Each sample runs through the 49-step restoring dividers (integral limit and
// derivative run side by side); sample_stall stays high until its result is
// loaded. The next sample is taken while the previous result still waits in the
// output register.
// Reset (rst_n, async, active low) clears gains, limits, integral and last error.
// ----------------------------------------------------------------------------
// PID deadband anti-windup controller, top level
// Fixed-point PID with deadband, integral clamp and output limit.
// ----------------------------------------------------------------------------
module pid_deadband_antiwindup_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [31:0] err_sample,
    input  logic [15:0]        time_step,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] correction,
    output logic               out_clamped,
    output logic               integ_clamped,
    output logic               step_zero
);

    pda_pkg::cmd_t cmd;
    pda_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    pda_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    pda_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .err_sample    (err_sample),
        .time_step     (time_step),
        .result_stall  (result_stall),
        .result_valid  (result_valid),
        .correction    (correction),
        .out_clamped   (out_clamped),
        .integ_clamped (integ_clamped),
        .step_zero     (step_zero)
    );

endmodule

// ===== design/pda_checker.sv =====
// ----------------------------------------------------------------------------
// PDA port checker
// Watches the top-level ports for sequencing and output-hold errors.
// ----------------------------------------------------------------------------
`include "pid_deadband_antiwindup_top_defines.svh"

module pda_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        sample_valid,
    input logic        sample_stall,
    input logic [31:0] err_sample,
    input logic [15:0] time_step,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] correction,
    input logic        out_clamped,
    input logic        integ_clamped,
    input logic        step_zero
);

    // one sample in flight: busy right after a transaction
    `PDA_ASSERT_NXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall)

    // a new result only appears as the block finishes a sample
    `PDA_ASSERT_IMP(a_result_from_work, $rose(result_valid), $past(sample_stall))

    // no result right after a transaction
    `PDA_ASSERT_NXT(a_no_early_result, sample_valid && !sample_stall, !$rose(result_valid))

    // stalled result holds
    `PDA_ASSERT_NXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(correction) && $stable(out_clamped) && $stable(integ_clamped) && $stable(step_zero))

    // stalled sample holds
    `PDA_ASSERT_NXT(a_sample_hold, sample_valid && sample_stall,
        sample_valid && $stable(err_sample) && $stable(time_step))

endmodule

bind pid_deadband_antiwindup_top pda_checker u_pda_checker (.*);

// ===== test/pid_deadband_antiwindup_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID deadband anti-windup controller testbench
// Drives samples and register writes and checks every correction against an
// internal fixed-point model of the controller or a fixed expected result.
// ----------------------------------------------------------------------------
module pid_deadband_antiwindup_top_test;

    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam longint     Q16_EPS      = 7;
    localparam longint     ACC_LIMIT    = (longint'(1) << 47) - 1;
    localparam longint unsigned PROD_CAP = longint'(1) << 61;
    localparam int         STALL_LIMIT  = 20000;
    localparam int         SETTLE       = 100;

    typedef struct {
        logic [31:0] corr;
        bit          oc;
        bit          ic;
        bit          sz;
    } ctrl_out_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [31:0] word;
        logic [15:0] dt;
        bit          fixed;
        ctrl_out_t   want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               sample_valid = 1'b0;
    logic               sample_stall;
    logic signed [31:0] err_sample = '0;
    logic [15:0]        time_step = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [31:0] correction;
    logic               out_clamped;
    logic               integ_clamped;
    logic               step_zero;

    // controller model state
    longint kp_q, ki_q, kd_q, band_q, maxc_q;
    longint integ_q, prev_err_q;

    ctrl_out_t pending_corr[$];
    int        errors = 0;
    int        send_idle = 27;
    int        recv_idle = 70;
    bit        next_fixed = 0;
    ctrl_out_t next_want;

    pid_deadband_antiwindup_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .err_sample    (err_sample),
        .time_step     (time_step),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .correction    (correction),
        .out_clamped   (out_clamped),
        .integ_clamped (integ_clamped),
        .step_zero     (step_zero)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic longint capped_product(longint a, longint b);
        longint unsigned ua, ub, m;
        bit neg;
        ua  = (a < 0) ? longint'(-a) : a;
        ub  = (b < 0) ? longint'(-b) : b;
        neg = (a < 0) != (b < 0);
        if (ua != 0 && ub > PROD_CAP / ua)
            m = PROD_CAP;
        else
            m = ua * ub;
        if (m > PROD_CAP)
            m = PROD_CAP;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic ctrl_out_t step_controller(logic [31:0] e_raw, logic [15:0] dt_raw);
        ctrl_out_t r;
        longint e, dt, den, lim, acc, d, sum, y;
        e  = longint'($signed(e_raw));
        dt = longint'(dt_raw);
        r.oc = 0;
        r.ic = 0;
        if (e > -band_q && e < band_q)
            e = 0;
        acc = integ_q + ((e * dt) >>> 16);
        den = ki_q + Q16_EPS;
        if (den < 0)
            den = -den;
        lim = (den == 0) ? ACC_LIMIT : (maxc_q * 65536) / den;
        if (acc > lim)
        begin
            acc  = lim;
            r.ic = 1;
        end
        if (acc < -lim)
        begin
            acc  = -lim;
            r.ic = 1;
        end
        integ_q = acc;
        d = (dt == 0) ? 0 : ((e - prev_err_q) * 65536) / dt;
        prev_err_q = e;
        sum = capped_product(kp_q, e) + capped_product(ki_q, acc) + capped_product(kd_q, d);
        y = sum >>> 16;
        if (y > maxc_q)
        begin
            y    = maxc_q;
            r.oc = 1;
        end
        if (y < -maxc_q)
        begin
            y    = -maxc_q;
            r.oc = 1;
        end
        r.corr = y[31:0];
        r.sz   = (dt == 0);
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // receiver back-pressure
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_idle);

    // predict at sample acceptance, check at result acceptance
    always @(posedge clk)
    begin
        ctrl_out_t p, w;
        if (rst_n && sample_valid && !sample_stall)
        begin
            p = step_controller(err_sample, time_step);
            pending_corr.push_back(next_fixed ? next_want : p);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_corr.size() == 0)
                report("unexpected transaction", correction, '0);
            else
            begin
                w = pending_corr.pop_front();
                if (correction !== w.corr)
                    report("correction", correction, w.corr);
                if (out_clamped !== w.oc)
                    report("out_clamped", 32'(out_clamped), 32'(w.oc));
                if (integ_clamped !== w.ic)
                    report("integ_clamped", 32'(integ_clamped), 32'(w.ic));
                if (step_zero !== w.sz)
                    report("step_zero", 32'(step_zero), 32'(w.sz));
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_sample(logic [31:0] e, logic [15:0] dt);
        while ($urandom_range(99) < send_idle)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        err_sample   <= e;
        time_step    <= dt;
        do
            @(posedge clk);
        while (!(sample_valid && !sample_stall));
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (pending_corr.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            pda_pkg::REG_KP:   kp_q   = longint'($signed(value));
            pda_pkg::REG_KI:   ki_q   = longint'($signed(value));
            pda_pkg::REG_KD:   kd_q   = longint'($signed(value));
            pda_pkg::REG_DB:   band_q = longint'(value[30:0]);
            pda_pkg::REG_MAXC: maxc_q = longint'(value[30:0]);
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(131072)) - 65536);
            2: return 32'($signed($urandom_range(2048)) - 1024);
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return '0;
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(3))
            0: return {1'b0, 31'($urandom_range(32'h7FFF_FFFF))};
            1: return $urandom_range(32'h0040_0000);
            2: return 32'h7FFF_FFFF;
            default: return $urandom_range(3);
        endcase
    endfunction

    function automatic logic [31:0] pick_error();
        logic signed [31:0] b;
        b = band_q[31:0];
        case ($urandom_range(5))
            0: return $urandom();
            1: return b + $signed($urandom_range(4)) - 2;
            2: return -b + $signed($urandom_range(4)) - 2;
            3: return 32'($signed($urandom_range(262144)) - 131072);
            4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return '0;
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(4))
            0: return '0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(16));
            default: return 16'($urandom());
        endcase
    endfunction

    stim_row_t directed[$];

    function automatic stim_row_t srow(logic [31:0] e, logic [15:0] dt, bit fx = 0,
                                       logic [31:0] c = 0, bit oc = 0, bit ic = 0,
                                       bit sz = 0);
        stim_row_t r;
        r.is_cfg = 0;
        r.idx    = '0;
        r.word   = e;
        r.dt     = dt;
        r.fixed  = fx;
        r.want   = '{c, oc, ic, sz};
        return r;
    endfunction

    function automatic stim_row_t crow(logic [2:0] idx, logic [31:0] value);
        stim_row_t r;
        r = srow(value, 0);
        r.is_cfg = 1;
        r.idx    = idx;
        return r;
    endfunction

    initial
    begin
        logic [2:0] reg_order[5];
        kp_q = 0; ki_q = 0; kd_q = 0; band_q = 0; maxc_q = 0;
        integ_q = 0; prev_err_q = 0;
        reg_order = '{pda_pkg::REG_KP, pda_pkg::REG_KI, pda_pkg::REG_KD,
                      pda_pkg::REG_DB, pda_pkg::REG_MAXC};

        // all gains and limits are zero out of reset
        directed.push_back(srow(32'h0000_0000, 16'h0000, 1, 0, 0, 0, 1));
        directed.push_back(srow(32'h7FFF_FFFF, 16'h0000, 1, 0, 0, 0, 1));
        directed.push_back(srow(32'h8000_0000, 16'h0000, 1, 0, 0, 0, 1));
        directed.push_back(srow(32'h0000_0000, 16'hFFFF, 1, 0, 0, 0, 0));
        directed.push_back(crow(pda_pkg::REG_KP, 32'h0001_0000));
        directed.push_back(crow(pda_pkg::REG_KI, 32'h0000_8000));
        directed.push_back(crow(pda_pkg::REG_KD, 32'h0000_0100));
        directed.push_back(crow(pda_pkg::REG_DB, 32'h0001_0000));
        directed.push_back(crow(pda_pkg::REG_MAXC, 32'h7FFF_FFFF));
        directed.push_back(srow(32'h0000_8000, 16'h1000));
        directed.push_back(srow(32'hFFFF_0000, 16'h1000));
        directed.push_back(srow(32'h7FFF_FFFF, 16'hFFFF));
        directed.push_back(srow(32'h8000_0000, 16'h0001));
        directed.push_back(srow(32'h0002_0000, 16'h0000));
        // zero adjusted integral gain: integral held only to its range
        directed.push_back(crow(pda_pkg::REG_KI, 32'hFFFF_FFF9));
        directed.push_back(srow(32'h7FFF_FFFF, 16'hFFFF));
        directed.push_back(srow(32'h7FFF_FFFF, 16'hFFFF));
        // negative adjusted gain, extreme gains, zero output limit
        directed.push_back(crow(pda_pkg::REG_KI, 32'h8000_0000));
        directed.push_back(crow(pda_pkg::REG_KP, 32'h7FFF_FFFF));
        directed.push_back(crow(pda_pkg::REG_KD, 32'h8000_0000));
        directed.push_back(crow(pda_pkg::REG_MAXC, 32'h0000_0000));
        directed.push_back(srow(32'h8000_0000, 16'h0001));
        // out-of-range indexes are dropped
        directed.push_back(crow(REG_SPARE_LO, 32'h0001_0000));
        directed.push_back(crow(REG_SPARE_HI, 32'hFFFF_FFFF));
        directed.push_back(srow(32'h0010_0000, 16'h0100));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                drain();
                write_reg(directed[i].idx, directed[i].word);
            end
            else
            begin
                next_fixed <= directed[i].fixed;
                next_want  <= directed[i].want;
                send_sample(directed[i].word, directed[i].dt);
            end
        end
        next_fixed <= 1'b0;

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 3)
            begin
                send_idle = 70;
                recv_idle = 27;
            end
            if (ph == 5)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            drain();
            foreach (reg_order[k])
            begin
                if (ph == 0)
                    write_reg(reg_order[k], (k < 3) ? pick_gain() :
                              (k == 3) ? 32'h0 : 32'h7FFF_FFFF);
                else if (k < 3)
                    write_reg(reg_order[k], pick_gain());
                else
                    write_reg(reg_order[k], pick_limit());
            end
            repeat (250) send_sample(pick_error(), pick_step());
        end

        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
